// ===== rtl/x931_pkg.sv =====
`default_nettype none
package x931_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC,
    ST_CHECK,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_DT,
    PH_R,
    PH_V
  } phase_t;

  localparam logic [2:0] REG_KEY_HIGH  = 3'd0;
  localparam logic [2:0] REG_KEY_LOW   = 3'd1;
  localparam logic [2:0] REG_SEED_HIGH = 3'd2;
  localparam logic [2:0] REG_SEED_LOW  = 3'd3;
  localparam logic [2:0] REG_COUNTER   = 3'd4;

  localparam logic [11:0] SAME_MASK = 12'h0fff;
  localparam logic [4:0]  BYTES_MAX = 5'd16;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon_next(input logic [7:0] rc);
    return xtime(rc);
  endfunction

  // byte i of a 128-bit big-endian block sits at bits 127-8i
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[127 - 8 * (c * 4 + j) -: 8] = sbox(s[127 - 8 * (((c + j) % 4) * 4 + j) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] t);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = t[127 - 32 * c -: 8];
      a1 = t[119 - 32 * c -: 8];
      a2 = t[111 - 32 * c -: 8];
      a3 = t[103 - 32 * c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      o[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      o[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      o[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      o[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return o;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w, w0, w1, w2, w3;
    w = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    w0 = k[127:96] ^ w;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/x931_aes_block_generator_core.sv =====
// sequence: each request runs three aes-128 encryptions of 10 rounds on one
//   round unit, then check and output; the first request after reset runs two
//   blocks, the first of which primes the compare
// requests: a new request is taken only in idle, after the last result is taken;
//   failed or zero-count requests give their result in the cycle after acceptance
// reset: synchronous active-low rst_n clears control, counters and state
`default_nettype none
module x931_aes_block_generator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_seconds,
  input  wire logic [19:0] in_microseconds,
  input  wire logic [4:0]  in_byte_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_random_high,
  output logic [63:0]      out_random_low,
  output logic             out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  x931_pkg::state_t state_r, state_nxt;
  x931_pkg::phase_t phase_r, phase_nxt;

  logic [127:0] key_r, seed_r, prev_r, iv_r, blk_r, rk_r, rk_nxt;
  logic [127:0] st_r, st_nxt;
  logic         prev_valid_r, failed_r, prime_r;
  logic [31:0]  seen_sec_r;
  logic [19:0]  seen_us_r;
  logic [11:0]  same_r;
  logic [63:0]  run_r;
  logic [31:0]  sec_r;
  logic [19:0]  us_r;
  logic [4:0]   cnt_r;
  logic [3:0]   round_r;
  logic [7:0]   rcon_r;
  logic [63:0]  oh_r, ol_r;
  logic         os_r;

  logic         start_dt;
  logic         same_time;
  logic [11:0]  same_new;
  logic [4:0]   cnt_sat;
  logic [127:0] mask;
  logic [127:0] round_out;

  assign in_stall  = (state_r != x931_pkg::ST_IDLE);
  assign cfg_ready = (state_r == x931_pkg::ST_IDLE);
  assign out_valid = (state_r == x931_pkg::ST_OUT);
  assign out_random_high = oh_r;
  assign out_random_low  = ol_r;
  assign out_status      = os_r;

  assign cnt_sat   = (in_byte_count > x931_pkg::BYTES_MAX) ? x931_pkg::BYTES_MAX : in_byte_count;
  assign same_time = (sec_r == seen_sec_r) && (us_r == seen_us_r);
  assign same_new  = same_time ? ((same_r + 12'd1) & x931_pkg::SAME_MASK) : 12'd0;

  assign rk_nxt    = x931_pkg::key_next(rk_r, rcon_r);
  assign round_out = (round_r == 4'd10) ? x931_pkg::sub_shift(st_r)
                   : x931_pkg::mix_cols(x931_pkg::sub_shift(st_r));

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mask[127 - 8 * i -: 8] = (5'(i) < cnt_r) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    start_dt  = 1'b0;
    st_nxt    = round_out ^ rk_nxt;
    case (state_r)
      x931_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (failed_r || in_byte_count == 5'd0) begin
            state_nxt = x931_pkg::ST_OUT;
          end else begin
            state_nxt = x931_pkg::ST_CHECK;
          end
        end
      end
      x931_pkg::ST_ENC: begin
        if (round_r == 4'd10) begin
          case (phase_r)
            x931_pkg::PH_DT: begin
              phase_nxt = x931_pkg::PH_R;
              st_nxt    = round_out ^ rk_nxt ^ seed_r ^ key_r;
            end
            x931_pkg::PH_R: begin
              phase_nxt = x931_pkg::PH_V;
              st_nxt    = round_out ^ rk_nxt ^ iv_r ^ key_r;
            end
            default: begin
              state_nxt = x931_pkg::ST_CHECK;
            end
          endcase
        end
      end
      x931_pkg::ST_CHECK: begin
        // entry from idle or after a block; prime_r marks a block computed for this request
        if (!prime_r) begin
          start_dt  = 1'b1;
          state_nxt = x931_pkg::ST_ENC;
          phase_nxt = x931_pkg::PH_DT;
        end else if (!prev_valid_r) begin
          start_dt  = 1'b1;
          state_nxt = x931_pkg::ST_ENC;
          phase_nxt = x931_pkg::PH_DT;
        end else begin
          state_nxt = x931_pkg::ST_OUT;
        end
      end
      x931_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = x931_pkg::ST_IDLE;
        end
      end
      default: state_nxt = x931_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= x931_pkg::ST_IDLE;
      phase_r      <= x931_pkg::PH_DT;
      key_r        <= '0;
      seed_r       <= '0;
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      failed_r     <= 1'b0;
      prime_r      <= 1'b0;
      seen_sec_r   <= '0;
      seen_us_r    <= '0;
      same_r       <= '0;
      run_r        <= '0;
      round_r      <= '0;
      rcon_r       <= 8'h01;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          x931_pkg::REG_KEY_HIGH:  key_r[127:64]  <= cfg_data;
          x931_pkg::REG_KEY_LOW:   key_r[63:0]    <= cfg_data;
          x931_pkg::REG_SEED_HIGH: seed_r[127:64] <= cfg_data;
          x931_pkg::REG_SEED_LOW:  seed_r[63:0]   <= cfg_data;
          x931_pkg::REG_COUNTER:   run_r          <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        x931_pkg::ST_IDLE: begin
          prime_r <= 1'b0;
          sec_r   <= in_seconds;
          us_r    <= in_microseconds;
          cnt_r   <= cnt_sat;
          oh_r    <= '0;
          ol_r    <= '0;
          os_r    <= failed_r;
        end
        x931_pkg::ST_CHECK: begin
          if (start_dt) begin
            if (prime_r) begin
              prev_r       <= blk_r;
              prev_valid_r <= 1'b1;
            end
            prime_r <= 1'b1;
            same_r  <= same_new;
            if (!same_time) begin
              seen_sec_r <= sec_r;
              seen_us_r  <= us_r;
            end
            st_r    <= {sec_r, us_r, same_new, run_r} ^ key_r;
            run_r   <= run_r + 64'd1;
            rk_r    <= key_r;
            rcon_r  <= 8'h01;
            round_r <= 4'd1;
          end else if (blk_r == prev_r) begin
            failed_r <= 1'b1;
            os_r     <= 1'b1;
          end else begin
            prev_r <= blk_r;
            oh_r   <= blk_r[127:64] & mask[127:64];
            ol_r   <= blk_r[63:0] & mask[63:0];
            os_r   <= 1'b0;
          end
        end
        x931_pkg::ST_ENC: begin
          st_r <= st_nxt;
          if (round_r == 4'd10) begin
            round_r <= 4'd1;
            rk_r    <= key_r;
            rcon_r  <= 8'h01;
            case (phase_r)
              x931_pkg::PH_DT: iv_r <= round_out ^ rk_nxt;
              x931_pkg::PH_R:  blk_r <= round_out ^ rk_nxt;
              default:         seed_r <= round_out ^ rk_nxt;
            endcase
          end else begin
            round_r <= round_r + 4'd1;
            rk_r    <= rk_nxt;
            rcon_r  <= x931_pkg::rcon_next(rcon_r);
          end
        end
        default: ;
      endcase
    end
  end

  a_busy_no_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == x931_pkg::ST_ENC) |-> !cfg_ready)
    else $error("config open while encrypting");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |=> failed_r)
    else $error("failure flag cleared");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_random_high == 64'd0 && out_random_low == 64'd0))
    else $error("data on failed result");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == x931_pkg::ST_ENC) |-> (round_r >= 4'd1 && round_r <= 4'd10))
    else $error("round out of range");

endmodule
`default_nettype wire

// ===== tb/sv/x931_aes_block_generator_core_tb.sv =====
`default_nettype none
module x931_aes_block_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_seconds;
  logic [19:0] in_microseconds;
  logic [4:0]  in_byte_count;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_random_high;
  logic [63:0] out_random_low;
  logic        out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  x931_aes_block_generator_core uut (.*);

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        st;
  } rand_word_t;

  typedef struct {
    logic [31:0] sec;
    logic [19:0] usec;
    logic [4:0]  nbytes;
    bit          typed;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        st;
  } req_row_t;

  logic [7:0] sub_lut [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // generator state as the block should hold it
  logic [127:0] key_q;
  logic [127:0] seed_q;
  logic [127:0] prev_q;
  bit           prev_ok;
  bit           gen_failed;
  logic [31:0]  seen_sec;
  logic [19:0]  seen_usec;
  logic [11:0]  same_cnt;
  logic [63:0]  run_cnt;

  rand_word_t   pending_words[$];
  int           errors;
  bit           quiet;
  int           out_hold;

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] f, a0, a1, a2, a3, all, rc;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = key[127 - 8 * i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i - 4 + j];
      if ((i & 15) == 0) begin
        f = w[0];
        w[0] = sub_lut[w[1]] ^ rc;
        w[1] = sub_lut[w[2]];
        w[2] = sub_lut[w[3]];
        w[3] = sub_lut[f];
        rc = gf_dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) t[c * 4 + j] = sub_lut[s[((c + j) & 3) * 4 + j]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c * 4];
          a1 = t[c * 4 + 1];
          a2 = t[c * 4 + 2];
          a3 = t[c * 4 + 3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[c * 4]     = a0 ^ all ^ gf_dbl(a0 ^ a1);
          t[c * 4 + 1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
          t[c * 4 + 2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
          t[c * 4 + 3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[r * 16 + i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
    return res;
  endfunction

  function automatic logic [127:0] next_block(input logic [31:0] sec, input logic [19:0] usec);
    logic [127:0] iv, r;
    if (sec == seen_sec && usec == seen_usec) begin
      same_cnt = same_cnt + 12'd1;
    end else begin
      same_cnt = '0;
      seen_sec = sec;
      seen_usec = usec;
    end
    iv = aes128(key_q, {sec, usec, same_cnt, run_cnt});
    run_cnt = run_cnt + 64'd1;
    r = aes128(key_q, iv ^ seed_q);
    seed_q = aes128(key_q, r ^ iv);
    return r;
  endfunction

  function automatic rand_word_t predict_word(input logic [31:0] sec, input logic [19:0] usec,
                                              input logic [4:0] nbytes);
    rand_word_t o;
    logic [127:0] r, mask;
    int n;
    n = (nbytes > x931_pkg::BYTES_MAX) ? 16 : int'(nbytes);
    o.hi = '0;
    o.lo = '0;
    o.st = gen_failed;
    if (gen_failed || n == 0) return o;
    r = next_block(sec, usec);
    if (!prev_ok) begin
      prev_q = r;
      prev_ok = 1;
      r = next_block(sec, usec);
    end
    if (r == prev_q) begin
      gen_failed = 1;
      o.st = 1'b1;
      return o;
    end
    prev_q = r;
    mask = ~({128{1'b1}} >> (8 * n));
    r = r & mask;
    o.hi = r[127:64];
    o.lo = r[63:0];
    o.st = 1'b0;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      x931_pkg::REG_KEY_HIGH:  key_q[127:64] = val;
      x931_pkg::REG_KEY_LOW:   key_q[63:0] = val;
      x931_pkg::REG_SEED_HIGH: seed_q[127:64] = val;
      x931_pkg::REG_SEED_LOW:  seed_q[63:0] = val;
      x931_pkg::REG_COUNTER:   run_cnt = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [63:0] kh, kl, sh, sl, cs);
    write_reg(x931_pkg::REG_KEY_HIGH, kh);
    write_reg(x931_pkg::REG_KEY_LOW, kl);
    write_reg(x931_pkg::REG_SEED_HIGH, sh);
    write_reg(x931_pkg::REG_SEED_LOW, sl);
    write_reg(x931_pkg::REG_COUNTER, cs);
  endtask

  task automatic send_request(input req_row_t row);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_seconds <= row.sec;
    in_microseconds <= row.usec;
    in_byte_count <= row.nbytes;
    do @(posedge clk); while (in_stall);
    if (row.typed) begin
      pending_words.push_back('{hi: row.hi, lo: row.lo, st: row.st});
    end else begin
      pending_words.push_back(predict_word(row.sec, row.usec, row.nbytes));
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_run(input int count);
    req_row_t row;
    logic [31:0] sec;
    logic [19:0] usec;
    sec = $urandom;
    usec = $urandom_range(0, 999999);
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3: sec = sec + 1;
        4: usec = $urandom_range(0, 999999);
        5: sec = ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0;
        6: usec = ($urandom_range(0, 1) != 0) ? 20'd999999 : 20'd0;
        default: begin
          sec = $urandom;
          usec = $urandom_range(0, 999999);
        end
      endcase
      row.sec = sec;
      row.usec = usec;
      case ($urandom_range(0, 9))
        0: row.nbytes = 5'd0;
        1: row.nbytes = 5'($urandom_range(17, 31));
        2: row.nbytes = 5'd16;
        default: row.nbytes = 5'($urandom_range(1, 16));
      endcase
      row.typed = 0;
      send_request(row);
    end
    quiet = 0;
    drain();
  endtask

  req_row_t directed [] = '{
    '{32'h0, 20'd0, 5'd0, 1, 64'h0, 64'h0, 1'b0},
    '{32'h0, 20'd0, 5'd16, 0, 64'h0, 64'h0, 1'b0},
    '{32'h0, 20'd0, 5'd1, 0, 64'h0, 64'h0, 1'b0},
    '{32'h0, 20'd0, 5'd8, 0, 64'h0, 64'h0, 1'b0},
    '{32'hffff_ffff, 20'd999999, 5'd16, 0, 64'h0, 64'h0, 1'b0},
    '{32'hffff_ffff, 20'd999999, 5'd31, 0, 64'h0, 64'h0, 1'b0},
    '{32'hffff_ffff, 20'd999999, 5'd17, 0, 64'h0, 64'h0, 1'b0},
    '{32'hffff_ffff, 20'd0, 5'd0, 1, 64'h0, 64'h0, 1'b0},
    '{32'h0, 20'd999999, 5'd9, 0, 64'h0, 64'h0, 1'b0},
    '{32'h8000_0001, 20'd524288, 5'd15, 0, 64'h0, 64'h0, 1'b0},
    '{32'h5555_aaaa, 20'd349525, 5'd7, 0, 64'h0, 64'h0, 1'b0},
    '{32'haaaa_5555, 20'd699050, 5'd2, 0, 64'h0, 64'h0, 1'b0},
    '{32'haaaa_5555, 20'd699050, 5'd12, 0, 64'h0, 64'h0, 1'b0},
    '{32'h1234_5678, 20'd1, 5'd4, 0, 64'h0, 64'h0, 1'b0},
    '{32'h1234_5678, 20'd1, 5'd0, 1, 64'h0, 64'h0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected result", out_random_high, 64'd0);
        end else begin
          if (out_random_high !== pending_words[0].hi)
            report_mismatch("random_high", out_random_high, pending_words[0].hi);
          if (out_random_low !== pending_words[0].lo)
            report_mismatch("random_low", out_random_low, pending_words[0].lo);
          if (out_status !== pending_words[0].st)
            report_mismatch("status", 64'(out_status), 64'(pending_words[0].st));
          void'(pending_words.pop_front());
        end
        out_hold = quiet ? 0 : $urandom_range(0, 14);
      end
      out_stall <= (out_hold > 0);
      if (out_hold > 0) out_hold--;
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    errors = 0;
    quiet = 0;
    key_q = '0;
    seed_q = '0;
    prev_q = '0;
    prev_ok = 0;
    gen_failed = 0;
    seen_sec = '0;
    seen_usec = '0;
    same_cnt = '0;
    run_cnt = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_seconds <= '0;
    in_microseconds <= '0;
    in_byte_count <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= x931_pkg::REG_KEY_HIGH;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_all('0, '0, '0, '0, '0);
    foreach (directed[i]) send_request(directed[i]);
    random_run(250);

    write_all('1, '1, '1, '1, '1);
    random_run(250);

    write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, 64'hffff_ffff_ffff_fff0);
    random_run(270);

    write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    random_run(270);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
